@@ rtl/core/slr_pkg.sv @@
`timescale 1ns / 1ps

package slr_pkg;

  localparam int COORD_BITS  = 11;
  localparam int DIFF_BITS   = COORD_BITS + 1;
  localparam int QSUM_BITS   = COORD_BITS + 2;
  localparam int CENTER_BITS = 10;
  localparam int SCREEN_BITS = 12;
  localparam int COLOR_BITS  = 4;
  localparam int CNT_BITS    = $clog2(COORD_BITS + 1);
  localparam int SUM_BITS    = ((COORD_BITS > SCREEN_BITS) ? COORD_BITS : SCREEN_BITS) + 1;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  localparam logic REG_CENTER_X = 1'b0;
  localparam logic REG_CENTER_Y = 1'b1;

  localparam logic [CENTER_BITS-1:0] CENTER_X_RESET = CENTER_BITS'(319);
  localparam logic [CENTER_BITS-1:0] CENTER_Y_RESET = CENTER_BITS'(239);

  typedef struct packed {
    logic take;
    logic load;
  } slr_cmd_t;

  typedef struct packed {
    logic div_done;
  } slr_status_t;

endpackage

@@ rtl/core/slr_div.sv @@
`timescale 1ns / 1ps

module slr_div import slr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [COORD_BITS-1:0] dividend,
  input  logic [COORD_BITS-1:0] divisor,
  output logic                  done,
  output logic [COORD_BITS-1:0] quot,
  output logic [COORD_BITS-1:0] rem
);

  logic                  run;
  logic [CNT_BITS-1:0]   cnt;
  logic [COORD_BITS-1:0] acc;
  logic [COORD_BITS-1:0] sh;
  logic [COORD_BITS-1:0] dvs;
  logic [COORD_BITS:0]   trial;
  logic                  fits;

  always_comb begin
    trial = {acc, sh[COORD_BITS-1]};
    fits  = trial >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CNT_BITS'(COORD_BITS);
      end else if (run) begin
        cnt <= cnt - CNT_BITS'(1);
        if (cnt == CNT_BITS'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      sh  <= dividend;
      dvs <= divisor;
    end else if (run) begin
      acc <= fits ? COORD_BITS'(trial - {1'b0, dvs}) : trial[COORD_BITS-1:0];
      sh  <= {sh[COORD_BITS-2:0], fits};
    end
  end

  assign quot = sh;
  assign rem  = acc;

endmodule

@@ rtl/core/slr_datapath.sv @@
`timescale 1ns / 1ps

module slr_datapath import slr_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  slr_cmd_t                      cmd,
  output slr_status_t                   status,
  input  logic                          cfg_write,
  input  logic                          cfg_index,
  input  logic [CENTER_BITS-1:0]        cfg_data,
  input  logic signed [COORD_BITS-1:0]  x_start,
  input  logic signed [COORD_BITS-1:0]  y_start,
  input  logic signed [COORD_BITS-1:0]  x_end,
  input  logic signed [COORD_BITS-1:0]  y_end,
  input  logic [COLOR_BITS-1:0]         color,
  output logic                          pixel_valid,
  output logic signed [SCREEN_BITS-1:0] screen_x,
  output logic signed [SCREEN_BITS-1:0] screen_y,
  output logic [COLOR_BITS-1:0]         pixel_color,
  output logic                          last
);

  logic [CENTER_BITS-1:0] center_x;
  logic [CENTER_BITS-1:0] center_y;

  logic signed [COORD_BITS-1:0] walk_pos;
  logic signed [COORD_BITS-1:0] walk_end;
  logic signed [COORD_BITS-1:0] base_x;
  logic [COLOR_BITS-1:0]        line_color;
  logic                         is_vertical;
  logic                         busy;
  logic                         dy_neg;
  logic [COORD_BITS-1:0]        den;
  logic signed [COORD_BITS-1:0] q;
  logic [COORD_BITS-1:0]        r;
  logic signed [DIFF_BITS-1:0]  dq;
  logic [COORD_BITS-1:0]        dr;

  logic signed [DIFF_BITS-1:0]  dx_in;
  logic signed [DIFF_BITS-1:0]  dy_in;
  logic [COORD_BITS-1:0]        den_in;
  logic [COORD_BITS-1:0]        dy_mag_in;
  logic                         vert_in;
  logic signed [COORD_BITS-1:0] pos_in;
  logic signed [COORD_BITS-1:0] end_in;

  logic                         div_done;
  logic [COORD_BITS-1:0]        quot;
  logic [COORD_BITS-1:0]        rem;
  logic signed [DIFF_BITS-1:0]  quot_ext;

  logic                         step_hit;
  logic [COORD_BITS:0]          r_sum;
  logic                         wrap;
  logic [COORD_BITS-1:0]        r_new;
  logic [QSUM_BITS-1:0]         q_sum;
  logic signed [COORD_BITS-1:0] y_line;
  logic signed [COORD_BITS-1:0] x_pix;
  logic signed [COORD_BITS-1:0] y_pix;
  logic signed [COORD_BITS-1:0] pos_step;
  logic [SUM_BITS-1:0]          sx_sum;
  logic [SUM_BITS-1:0]          sy_sum;

  always_comb begin
    dx_in     = DIFF_BITS'(x_end) - DIFF_BITS'(x_start);
    dy_in     = DIFF_BITS'(y_end) - DIFF_BITS'(y_start);
    den_in    = dx_in[COORD_BITS] ? COORD_BITS'(-dx_in) : dx_in[COORD_BITS-1:0];
    dy_mag_in = dy_in[COORD_BITS] ? COORD_BITS'(-dy_in) : dy_in[COORD_BITS-1:0];
    vert_in   = (dx_in == '0);
    pos_in    = vert_in ? y_start : x_start;
    end_in    = vert_in ? y_end : x_end;
  end

  slr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.load),
    .dividend (dy_mag_in),
    .divisor  (den_in),
    .done     (div_done),
    .quot     (quot),
    .rem      (rem)
  );

  assign status.div_done = div_done;
  assign quot_ext = $signed({1'b0, quot});

  // The row is kept as a floored quotient and remainder of the scaled row
  // over |dx|, advanced by the floored quotient of dy over |dx| per column.
  always_comb begin
    step_hit = cmd.take && !cmd.load && busy;
    r_sum    = {1'b0, r} + {1'b0, dr};
    wrap     = r_sum >= {1'b0, den};
    r_new    = wrap ? COORD_BITS'(r_sum - {1'b0, den}) : r_sum[COORD_BITS-1:0];
    q_sum    = QSUM_BITS'(q) + QSUM_BITS'(dq) + QSUM_BITS'(wrap);
    y_line   = q + COORD_BITS'(q[COORD_BITS-1] && (r != '0));
    x_pix    = is_vertical ? base_x : walk_pos;
    y_pix    = is_vertical ? walk_pos : y_line;
    pos_step = (walk_pos < walk_end) ? walk_pos + COORD_BITS'(1)
                                     : walk_pos - COORD_BITS'(1);
    sx_sum   = SUM_BITS'(x_pix) + SUM_BITS'(center_x);
    sy_sum   = SUM_BITS'(center_y) - SUM_BITS'(y_pix);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= CENTER_X_RESET;
      center_y <= CENTER_Y_RESET;
      busy     <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_CENTER_X: center_x <= cfg_data;
          REG_CENTER_Y: center_y <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load) begin
        busy <= (pos_in != end_in);
      end else if (step_hit && (pos_step == walk_end)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      walk_pos    <= pos_in;
      walk_end    <= end_in;
      base_x      <= x_end;
      line_color  <= color;
      is_vertical <= vert_in;
      dy_neg      <= dy_in[COORD_BITS];
      den         <= den_in;
      q           <= y_start;
      r           <= '0;
    end else if (step_hit) begin
      walk_pos <= pos_step;
      q        <= q_sum[COORD_BITS-1:0];
      r        <= r_new;
    end
    if (div_done) begin
      if (!dy_neg) begin
        dq <= quot_ext;
        dr <= rem;
      end else if (rem == '0) begin
        dq <= -quot_ext;
        dr <= '0;
      end else begin
        dq <= -quot_ext - DIFF_BITS'(1);
        dr <= den - rem;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      if (step_hit) begin
        pixel_valid <= 1'b1;
        screen_x    <= sx_sum[SCREEN_BITS-1:0];
        screen_y    <= sy_sum[SCREEN_BITS-1:0];
        pixel_color <= line_color;
        last        <= (pos_step == walk_end);
      end else begin
        pixel_valid <= 1'b0;
        screen_x    <= '0;
        screen_y    <= '0;
        pixel_color <= '0;
        last        <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/core/slr_ctrl.sv @@
`timescale 1ns / 1ps

module slr_ctrl import slr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        command,
  input  logic        out_ready,
  input  slr_status_t status,
  output logic        in_ready,
  output logic        out_valid,
  output slr_cmd_t    cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DIV  = 1'b1;

  logic state;
  logic state_next;

  always_comb begin
    in_ready = (state == ST_IDLE) && (!out_valid || out_ready);
    cmd.take = in_valid && in_ready;
    cmd.load = cmd.take && (command == CMD_LOAD);
    state_next = state;
    unique case (state)
      ST_IDLE: if (cmd.load) state_next = ST_DIV;
      ST_DIV:  if (status.div_done) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.take) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/core/slope_intercept_line_raster.sv @@
`timescale 1ns / 1ps

// Line rasteriser in centred coordinates. Every transfer on the input channel
// gives exactly one result: a load gives an empty result and then holds the
// input off while a bit-serial divider works out dy over |dx|; each step after
// that advances the row by that quotient and its remainder rather than dividing
// afresh, so pixels flow at one per cycle while the output is taken. The
// centre registers are written through the configuration channel, which is
// always ready.
module slope_intercept_line_raster import slr_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          command,
  input  logic signed [COORD_BITS-1:0]  x_start,
  input  logic signed [COORD_BITS-1:0]  y_start,
  input  logic signed [COORD_BITS-1:0]  x_end,
  input  logic signed [COORD_BITS-1:0]  y_end,
  input  logic [COLOR_BITS-1:0]         color,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          pixel_valid,
  output logic signed [SCREEN_BITS-1:0] screen_x,
  output logic signed [SCREEN_BITS-1:0] screen_y,
  output logic [COLOR_BITS-1:0]         pixel_color,
  output logic                          last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [CENTER_BITS-1:0]        cfg_data
);

  slr_cmd_t    cmd;
  slr_status_t status;

  assign cfg_ready = 1'b1;

  slr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .command   (command),
    .out_ready (out_ready),
    .status    (status),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  slr_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_write   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .x_start     (x_start),
    .y_start     (y_start),
    .x_end       (x_end),
    .y_end       (y_end),
    .color       (color),
    .pixel_valid (pixel_valid),
    .screen_x    (screen_x),
    .screen_y    (screen_y),
    .pixel_color (pixel_color),
    .last        (last)
  );

endmodule

@@ rtl/core/slr_checker.sv @@
`timescale 1ns / 1ps

module slr_checker import slr_pkg::*; (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          command,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          pixel_valid,
  input logic signed [SCREEN_BITS-1:0] screen_x,
  input logic signed [SCREEN_BITS-1:0] screen_y,
  input logic [COLOR_BITS-1:0]         pixel_color,
  input logic                          last
);

  // A load holds the input off while the divider runs.
  a_load_blocks: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (command == CMD_LOAD) |=> !in_ready)
    else $error("input ready straight after a load transfer");

  a_load_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (command == CMD_LOAD) |=> out_valid && !pixel_valid)
    else $error("load transfer did not give an empty result");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pixel_valid |->
      (screen_x == '0) && (screen_y == '0) && (pixel_color == '0) && !last)
    else $error("empty result carries non-zero fields");

  a_last_pixel: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> pixel_valid)
    else $error("last flag on a result without a pixel");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pixel_valid) &&
      $stable(screen_x) && $stable(screen_y) && $stable(pixel_color) && $stable(last))
    else $error("stalled result changed");

endmodule

bind slope_intercept_line_raster slr_checker u_checker (.*);

@@ tb/tb_slope_intercept_line_raster.sv @@
`timescale 1ns / 1ps

module tb_slope_intercept_line_raster;
  import slr_pkg::*;

  typedef struct packed {
    logic                          cmd;
    logic signed [COORD_BITS-1:0]  xs;
    logic signed [COORD_BITS-1:0]  ys;
    logic signed [COORD_BITS-1:0]  xe;
    logic signed [COORD_BITS-1:0]  ye;
    logic [COLOR_BITS-1:0]         col;
  } line_cmd_t;

  typedef struct packed {
    logic                          pv;
    logic signed [SCREEN_BITS-1:0] sx;
    logic signed [SCREEN_BITS-1:0] sy;
    logic [COLOR_BITS-1:0]         col;
    logic                          last;
  } pixel_res_t;

  typedef struct packed {
    line_cmd_t  item;
    logic       typed;
    pixel_res_t res;
  } dir_row_t;

  localparam pixel_res_t NO_PIXEL = '0;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic                          command = CMD_STEP;
  logic signed [COORD_BITS-1:0]  x_start = '0;
  logic signed [COORD_BITS-1:0]  y_start = '0;
  logic signed [COORD_BITS-1:0]  x_end = '0;
  logic signed [COORD_BITS-1:0]  y_end = '0;
  logic [COLOR_BITS-1:0]         color = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic                          pixel_valid;
  logic signed [SCREEN_BITS-1:0] screen_x;
  logic signed [SCREEN_BITS-1:0] screen_y;
  logic [COLOR_BITS-1:0]         pixel_color;
  logic                          last;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic                          cfg_index = REG_CENTER_X;
  logic [CENTER_BITS-1:0]        cfg_data = '0;

  logic       typed_chk = 1'b0;
  pixel_res_t typed_res = NO_PIXEL;
  bit         no_idle = 1'b0;

  logic [CENTER_BITS-1:0]        org_x = CENTER_X_RESET;
  logic [CENTER_BITS-1:0]        org_y = CENTER_Y_RESET;
  logic signed [COORD_BITS-1:0]  walk_at = '0;
  logic signed [COORD_BITS-1:0]  walk_stop = '0;
  logic signed [COORD_BITS-1:0]  end_x = '0;
  logic signed [COORD_BITS-1:0]  end_y = '0;
  logic signed [DIFF_BITS-1:0]   d_x = '0;
  logic signed [DIFF_BITS-1:0]   d_y = '0;
  logic [COLOR_BITS-1:0]         hue = '0;
  logic                          vert = 1'b0;
  logic                          active = 1'b0;

  pixel_res_t pixel_q[$];
  int errors = 0;
  int n_loads = 0;
  int n_pixels = 0;
  int n_lines = 0;
  int n_empty = 0;

  dir_row_t dir_tab [25] = '{
    '{'{CMD_STEP, 0, 0, 0, 0, 0}, 1'b1, NO_PIXEL},
    '{'{CMD_LOAD, -1024, 1023, 1023, -1024, 15}, 1'b1, NO_PIXEL},
    '{'{CMD_STEP, -1, -1, -1, -1, 15}, 1'b1, '{1'b1, -705, -784, 15, 1'b0}},
    '{'{CMD_STEP, 0, 0, 0, 0, 0}, 1'b0, NO_PIXEL},
    '{'{CMD_LOAD, 5, 5, 5, 5, 3}, 1'b1, NO_PIXEL},
    '{'{CMD_STEP, 0, 0, 0, 0, 0}, 1'b1, NO_PIXEL},
    '{'{CMD_LOAD, 7, -2, 7, 1, 9}, 1'b1, NO_PIXEL},
    '{'{CMD_STEP, 0, 0, 0, 0, 0}, 1'b0, NO_PIXEL},
    '{'{CMD_STEP, 0, 0, 0, 0, 0}, 1'b0, NO_PIXEL},
    '{'{CMD_STEP, 0, 0, 0, 0, 0}, 1'b0, NO_PIXEL},
    '{'{CMD_STEP, 0, 0, 0, 0, 0}, 1'b1, NO_PIXEL},
    '{'{CMD_LOAD, -3, 2, -3, -1, 6}, 1'b1, NO_PIXEL},
    '{'{CMD_STEP, 0, 0, 0, 0, 0}, 1'b0, NO_PIXEL},
    '{'{CMD_STEP, 0, 0, 0, 0, 0}, 1'b0, NO_PIXEL},
    '{'{CMD_STEP, 0, 0, 0, 0, 0}, 1'b0, NO_PIXEL},
    '{'{CMD_LOAD, 4, 0, 1, 3, 0}, 1'b1, NO_PIXEL},
    '{'{CMD_STEP, 0, 0, 0, 0, 0}, 1'b0, NO_PIXEL},
    '{'{CMD_STEP, 0, 0, 0, 0, 0}, 1'b0, NO_PIXEL},
    '{'{CMD_STEP, 0, 0, 0, 0, 0}, 1'b0, NO_PIXEL},
    '{'{CMD_LOAD, 1023, 1023, 1023, -1024, 10}, 1'b1, NO_PIXEL},
    '{'{CMD_STEP, 0, 0, 0, 0, 0}, 1'b1, '{1'b1, 1342, -784, 10, 1'b0}},
    '{'{CMD_LOAD, 0, 0, 3, -1000, 1}, 1'b1, NO_PIXEL},
    '{'{CMD_STEP, 0, 0, 0, 0, 0}, 1'b0, NO_PIXEL},
    '{'{CMD_STEP, 0, 0, 0, 0, 0}, 1'b0, NO_PIXEL},
    '{'{CMD_STEP, 0, 0, 0, 0, 0}, 1'b0, NO_PIXEL}
  };

  slope_intercept_line_raster uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .command(command),
    .x_start(x_start),
    .y_start(y_start),
    .x_end(x_end),
    .y_end(y_end),
    .color(color),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .pixel_valid(pixel_valid),
    .screen_x(screen_x),
    .screen_y(screen_y),
    .pixel_color(pixel_color),
    .last(last),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic pixel_res_t raster_next(input line_cmd_t c);
    pixel_res_t r;
    longint num;
    longint den;
    int px;
    int py;
    r = NO_PIXEL;
    if (c.cmd == CMD_LOAD) begin
      d_x = DIFF_BITS'(int'($signed(c.xe)) - int'($signed(c.xs)));
      d_y = DIFF_BITS'(int'($signed(c.ye)) - int'($signed(c.ys)));
      end_x = c.xe;
      end_y = c.ye;
      hue = c.col;
      vert = (d_x == 0);
      walk_at = vert ? c.ys : c.xs;
      walk_stop = vert ? c.ye : c.xe;
      active = (walk_at != walk_stop);
    end else if (active) begin
      if (vert) begin
        px = end_x;
        py = walk_at;
      end else begin
        num = longint'(end_y) * longint'(d_x)
            + longint'(d_y) * (longint'(walk_at) - longint'(end_x));
        den = longint'(d_x);
        if (den < 0) begin
          num = -num;
          den = -den;
        end
        px = walk_at;
        py = int'(num / den);
      end
      if (walk_at < walk_stop) walk_at = walk_at + 1;
      else walk_at = walk_at - 1;
      r.last = (walk_at == walk_stop);
      if (r.last) active = 1'b0;
      r.pv = 1'b1;
      r.sx = SCREEN_BITS'(px + int'(org_x));
      r.sy = SCREEN_BITS'(int'(org_y) - py);
      r.col = hue;
    end
    return r;
  endfunction

  task automatic report_field(input string fname, input logic signed [12:0] want,
                              input logic signed [12:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : monitor
    line_cmd_t  cur;
    pixel_res_t want;
    pixel_res_t got;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_CENTER_X) org_x = cfg_data;
        else org_y = cfg_data;
      end
      if (in_valid && in_ready) begin
        cur = '{command, x_start, y_start, x_end, y_end, color};
        if (command == CMD_LOAD) n_loads++;
        want = raster_next(cur);
        pixel_q.push_back(typed_chk ? typed_res : want);
      end
      if (out_valid && out_ready) begin
        got = '{pixel_valid, screen_x, screen_y, pixel_color, last};
        if (pixel_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual x %0d y %0d", $time,
                   screen_x, screen_y);
          errors++;
        end else begin
          want = pixel_q.pop_front();
          report_field("pixel_valid", want.pv, got.pv);
          report_field("screen_x", want.sx, got.sx);
          report_field("screen_y", want.sy, got.sy);
          report_field("pixel_color", want.col, got.col);
          report_field("last", want.last, got.last);
        end
        if (got.pv === 1'b1) n_pixels++;
        else n_empty++;
        if (got.last === 1'b1) n_lines++;
      end
    end
  end

  initial begin : receiver
    int k;
    @(negedge rst);
    forever begin
      k = no_idle ? 0 : $urandom_range(0, 3);
      repeat (k) begin
        @(negedge clk);
        out_ready <= 1'b0;
      end
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_item(input line_cmd_t c, input logic chk, input pixel_res_t res);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    command <= c.cmd;
    x_start <= c.xs;
    y_start <= c.ys;
    x_end <= c.xe;
    y_end <= c.ye;
    color <= c.col;
    typed_chk <= chk;
    typed_res <= res;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_origin(input logic idx, input logic [CENTER_BITS-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    line_cmd_t c;
    line_cmd_t st;
    int ph;
    int n_rand;
    int kind;
    int xs;
    int ys;
    int dx;
    int dy;
    int len;
    int nsteps;
    logic [CENTER_BITS-1:0] ox [5];
    logic [CENTER_BITS-1:0] oy [5];
    ox = '{10'd0, 10'd1023, 10'd0, 10'd1023, CENTER_BITS'($urandom)};
    oy = '{10'd0, 10'd1023, 10'd1023, 10'd0, CENTER_BITS'($urandom)};
    n_rand = 0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) send_item(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].res);

    for (ph = 0; ph < 5; ph++) begin
      hold_until_drained();
      repeat (16) @(posedge clk);
      write_origin(REG_CENTER_X, ox[ph]);
      write_origin(REG_CENTER_Y, oy[ph]);
      no_idle = (ph == 2);
      while (n_rand < (ph + 1) * 305) begin
        xs = int'($urandom_range(0, 2047)) - 1024;
        ys = int'($urandom_range(0, 2047)) - 1024;
        kind = $urandom_range(0, 99);
        if (kind < 55) begin
          dx = int'($urandom_range(0, 24)) - 12;
          dy = int'($urandom_range(0, 80)) - 40;
        end else if (kind < 70) begin
          dx = 0;
          dy = int'($urandom_range(0, 30)) - 15;
        end else if (kind < 85) begin
          dx = int'($urandom_range(0, 8)) - 4;
          dy = int'($urandom_range(0, 2048)) - 1024;
        end else if (kind < 95) begin
          dx = int'($urandom_range(0, 2048)) - 1024;
          dy = int'($urandom_range(0, 2048)) - 1024;
        end else begin
          dx = 0;
          dy = 0;
        end
        if (xs + dx > 1023 || xs + dx < -1024) dx = -dx;
        if (ys + dy > 1023 || ys + dy < -1024) dy = -dy;
        c = '{CMD_LOAD, xs, ys, xs + dx, ys + dy, $urandom};
        len = (dx != 0) ? ((dx < 0) ? -dx : dx) : ((dy < 0) ? -dy : dy);
        if (len > 40 || $urandom_range(0, 4) == 0)
          nsteps = $urandom_range(0, (len > 40) ? 40 : len);
        else
          nsteps = len + $urandom_range(0, 2);
        send_item(c, 1'b0, NO_PIXEL);
        n_rand++;
        repeat (nsteps) begin
          st = '{CMD_STEP, $urandom, $urandom, $urandom, $urandom, $urandom};
          send_item(st, 1'b0, NO_PIXEL);
          n_rand++;
        end
        if ($urandom_range(0, 29) == 0) hold_until_drained();
      end
    end

    hold_until_drained();
    repeat (20) @(posedge clk);
    $display("Ran %0d loads under six origin settings: %0d pixels drawn, %0d lines completed.",
             n_loads, n_pixels, n_lines);
    $display("%0d empty results from loads and steps with nothing left to draw.", n_empty);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ slope_intercept_line_raster.f @@
rtl/core/slr_pkg.sv
rtl/core/slr_div.sv
rtl/core/slr_datapath.sv
rtl/core/slr_ctrl.sv
rtl/core/slope_intercept_line_raster.sv
rtl/core/slr_checker.sv
tb/tb_slope_intercept_line_raster.sv
